>>> rtl/core/pspc_pkg.sv
// shared widths, reset values, ratio constants and codes of the pedal sensor plausibility check
package pspc_pkg;

	// field widths
	localparam int COUNT_BITS     = 16;
	localparam int POSITION_MAX   = 1023;
	localparam int POS_BITS       = $clog2(POSITION_MAX + 1);
	localparam int FS_BITS        = 16;
	localparam int TICK_BITS      = 32;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int FAULT_BITS     = 3;
	localparam int VAL_BITS       = (COUNT_BITS > FS_BITS) ? COUNT_BITS : FS_BITS;

	// register reset values
	localparam logic [FS_BITS-1:0]   PRIMARY_FS_RESET       = FS_BITS'(1400);
	localparam logic [FS_BITS-1:0]   SECONDARY_FS_RESET     = FS_BITS'(1950);
	localparam logic [TICK_BITS-1:0] FAULT_TICK_LIMIT_RESET = TICK_BITS'(1000);
	localparam logic [TICK_BITS-1:0] STUCK_TICK_LIMIT_RESET = TICK_BITS'(10000);

	// ratios as exact cross-multiplication factors
	localparam int DZ_DEN     = 100; // deadzone 3 %
	localparam int DZ_NUM     = 3;
	localparam int SAT_P      = 5;   // saturation 80 %: p*5 > fs*4
	localparam int SAT_FS     = 4;
	localparam int RELEASE_P  = 25;  // release 4 %: p*25 < fs
	localparam int OVERLAP_P  = 4;   // brake overlap 25 %: p*4 > fs
	localparam int RECOVER_P  = 20;  // recovery 5 %: p*20 < fs
	localparam int DIFFER_MAG = 10;  // sensor difference 10 %

	typedef enum logic [FAULT_BITS-1:0] {
		FAULT_NONE,
		FAULT_OPEN_SHORT,
		FAULT_DIFFER,
		FAULT_OVERLAP,
		FAULT_STUCK
	} fault_code_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PRIMARY_FS,
		CFG_SECONDARY_FS,
		CFG_FAULT_LIMIT,
		CFG_STUCK_LIMIT
	} cfg_index_t;

endpackage

>>> rtl/core/pspc_in_if.sv
// sample channel: one sensor reading word with valid/ready
interface pspc_in_if;
	import pspc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  loop_mode;
	logic [COUNT_BITS-1:0] primary_count;
	logic [COUNT_BITS-1:0] secondary_count;
	logic                  brake_pressed;
	logic                  primary_alarm;
	logic                  secondary_alarm;

	modport source (
		output valid, loop_mode, primary_count, secondary_count,
		output brake_pressed, primary_alarm, secondary_alarm,
		input  ready
	);

	modport sink (
		input  valid, loop_mode, primary_count, secondary_count,
		input  brake_pressed, primary_alarm, secondary_alarm,
		output ready
	);
endinterface

>>> rtl/core/pspc_out_if.sv
// result channel: pedal position and fault code word with valid/ready
interface pspc_out_if;
	import pspc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [POS_BITS-1:0]   pedal_position;
	logic [FAULT_BITS-1:0] fault_code;

	modport source (output valid, pedal_position, fault_code, input ready);
	modport sink (input valid, pedal_position, fault_code, output ready);
endinterface

>>> rtl/core/pspc_cfg_if.sv
// configuration write channel: register index and data with valid/ready
interface pspc_cfg_if;
	import pspc_pkg::*;

	logic                     valid;
	logic                     ready;
	cfg_index_t               index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/pedal_sensor_plausibility_check.sv
// accelerator pedal sensor plausibility check, bit-serial datapath and fault sequencer
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+------------------------------------------------
//  sample   | in  | valid / ready | loop_mode, primary/secondary count, brake, alarms
//  result   | out | valid / ready | pedal_position, fault_code
//  cfg      | in  | valid / ready | index (0..3), data; ready is always high
//
// one word at a time: a new sample is taken only once the previous word has left the final step
// the cross product of the two sensor readings takes one full-scale bit per cycle,
// and the position divider one quotient bit per cycle
// reset loads the full-scale and tick-limit defaults, fault state normal, counter zero
// a finished word waits in the result register while the next sample is worked on;
// the last step holds only while that register is still full
module pedal_sensor_plausibility_check (
	input  logic                clk,
	input  logic                arst_n,
	pspc_in_if.sink             sample,
	pspc_out_if.source          result,
	pspc_cfg_if.sink            cfg
);
	import pspc_pkg::*;

	// datapath widths
	localparam int DZ_BITS       = VAL_BITS + 7;          // x*100
	localparam int CMP_BITS      = VAL_BITS + 5;          // x*25
	localparam int MAG_BITS      = VAL_BITS + FS_BITS;    // |p*fss - s*fsp|
	localparam int ACC_BITS      = MAG_BITS + 1;          // signed difference
	localparam int PROD_BITS     = 2 * FS_BITS;           // fsp*fss
	localparam int DIFF_CMP_BITS = MAG_BITS + 4;          // |diff|*10
	localparam int NUM_BITS      = FS_BITS + POS_BITS;    // p*POSITION_MAX
	localparam int SER_CYCLES    = (FS_BITS > POS_BITS) ? FS_BITS : POS_BITS;
	localparam int CNT_BITS      = $clog2(SER_CYCLES);

	localparam logic [POS_BITS-1:0] POS_FULL   = POS_BITS'(POSITION_MAX);
	localparam logic [NUM_BITS-1:0] POS_FULL_N = NUM_BITS'(POSITION_MAX);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DZ_P,
		S_DZ_S,
		S_CMP_A,
		S_CMP_B,
		S_CMP_C,
		S_MUL,
		S_ABS,
		S_DIFF,
		S_DIV,
		S_CHK_ALARM,
		S_CHK_DIFF,
		S_CHK_BRAKE,
		S_CHK_STUCK,
		S_FINAL
	} fsm_t;

	// reading inside 3 % of full scale from zero or from wrap-around
	function automatic logic in_deadzone(input logic [COUNT_BITS-1:0] x,
			input logic [FS_BITS-1:0] fs);
		logic [COUNT_BITS-1:0] xn;
		logic [DZ_BITS-1:0]    lim;
		logic [DZ_BITS-1:0]    lo;
		logic [DZ_BITS-1:0]    hi;
		xn  = ~x;
		lim = DZ_BITS'(fs) * DZ_BITS'(DZ_NUM);
		lo  = DZ_BITS'(x) * DZ_BITS'(DZ_DEN);
		hi  = DZ_BITS'(xn) * DZ_BITS'(DZ_DEN);
		return (lo < lim) || (hi < lim);
	endfunction

	// control state
	fsm_t                  fsm_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [FS_BITS-1:0]    primary_fs_q;
	logic [FS_BITS-1:0]    secondary_fs_q;
	logic [TICK_BITS-1:0]  fault_limit_q;
	logic [TICK_BITS-1:0]  stuck_limit_q;
	fault_code_t           fault_state_q;
	logic [TICK_BITS-1:0]  fault_ticks_q;
	logic                  flag_q;
	logic                  res_valid_q;
	logic [POS_BITS-1:0]   res_pos_q;
	fault_code_t           res_code_q;

	// per-word working registers
	logic                  loop_q;
	logic                  brake_q;
	logic                  alarm_q;
	logic                  skip_q;      // word arrived with state 2 latched
	logic                  gate_q;      // alarm and difference checks enabled
	logic [VAL_BITS-1:0]   p_q;
	logic [VAL_BITS-1:0]   s_q;
	logic [FS_BITS-1:0]    fsp_q;
	logic [FS_BITS-1:0]    fss_q;
	logic [TICK_BITS-1:0]  saved_q;
	logic                  range_bad_q;
	logic                  sat_q;
	logic                  low_q;
	logic                  over_q;
	logic                  recover_q;
	logic                  differ_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [MAG_BITS-1:0]   mag_q;
	logic [FS_BITS-1:0]    mul_p_q;     // secondary full scale, msb first
	logic [FS_BITS-1:0]    mul_s_q;     // primary full scale, msb first
	logic [FS_BITS-1:0]    rem_q;
	logic [POS_BITS-1:0]   qn_q;        // numerator low bits in, quotient bits out
	logic [POS_BITS-1:0]   pos_q;

	// handshakes
	logic in_take;
	logic res_free;
	logic commit;

	assign sample.ready          = (fsm_q == S_IDLE);
	assign in_take               = sample.valid && sample.ready;
	assign res_free              = !res_valid_q || result.ready;
	assign commit                = (fsm_q == S_FINAL) && res_free;
	assign cfg.ready             = 1'b1;
	assign result.valid          = res_valid_q;
	assign result.pedal_position = res_pos_q;
	assign result.fault_code     = res_code_q;

	// secondary counts downward
	logic [COUNT_BITS-1:0] sec_inv;
	assign sec_inv = ~sample.secondary_count;

	// scaled numerator for the position divider
	logic [NUM_BITS-1:0] num_w;
	assign num_w = NUM_BITS'(p_q[FS_BITS-1:0]) * POS_FULL_N;

	// one step of the bit-serial cross multiplier
	logic [ACC_BITS-1:0]  mul_add;
	logic [ACC_BITS-1:0]  mul_sub;
	logic [ACC_BITS-1:0]  acc_next;
	logic [ACC_BITS-1:0]  acc_neg;
	logic [PROD_BITS-1:0] prod_next;

	assign mul_add   = mul_p_q[FS_BITS-1] ? ACC_BITS'(p_q) : '0;
	assign mul_sub   = mul_s_q[FS_BITS-1] ? ACC_BITS'(s_q) : '0;
	assign acc_next  = {acc_q[ACC_BITS-2:0], 1'b0} + mul_add - mul_sub;
	assign acc_neg   = '0 - acc_q;
	assign prod_next = {prod_q[PROD_BITS-2:0], 1'b0}
		+ (mul_p_q[FS_BITS-1] ? PROD_BITS'(fsp_q) : '0);

	// one step of the restoring divider
	logic [FS_BITS:0] div_t;
	logic [FS_BITS:0] div_sub;
	logic             div_ge;

	assign div_t   = {rem_q, qn_q[POS_BITS-1]};
	assign div_ge  = div_t >= {1'b0, fsp_q};
	assign div_sub = div_t - {1'b0, fsp_q};

	// fault checks, one per cycle
	logic                 stuck;
	logic                 chk_hit;
	logic                 chk_over;
	fault_code_t          chk_state;
	fsm_t                 chk_next;
	logic [TICK_BITS-1:0] ticks_inc;

	assign stuck     = !brake_q && !range_bad_q && sat_q;
	assign ticks_inc = (fault_ticks_q == '1) ? fault_ticks_q
		: fault_ticks_q + TICK_BITS'(1);
	assign chk_over  = (fsm_q == S_CHK_STUCK) ? (fault_ticks_q > stuck_limit_q)
		: (fault_ticks_q > fault_limit_q);

	always_comb begin
		chk_hit   = 1'b0;
		chk_state = FAULT_OVERLAP;
		chk_next  = S_FINAL;
		unique case (fsm_q)
			S_CHK_ALARM: begin
				chk_hit   = !skip_q && gate_q && alarm_q;
				chk_state = FAULT_DIFFER;
				chk_next  = S_CHK_DIFF;
			end
			S_CHK_DIFF: begin
				chk_hit  = !skip_q && gate_q && differ_q;
				chk_next = S_CHK_BRAKE;
			end
			S_CHK_BRAKE: begin
				chk_hit  = !skip_q && over_q && brake_q;
				chk_next = S_CHK_STUCK;
			end
			S_CHK_STUCK: begin
				chk_hit   = !skip_q && stuck;
				chk_state = FAULT_STUCK;
			end
			default: begin
				chk_hit = 1'b0;
			end
		endcase
	end

	// closing decision of a word
	fault_code_t          fin_state;
	logic [TICK_BITS-1:0] fin_ticks;
	logic [POS_BITS-1:0]  fin_pos;

	always_comb begin
		fin_state = fault_state_q;
		fin_ticks = fault_ticks_q;
		fin_pos   = pos_q;
		if (skip_q) begin
			// latched state 2: nothing moves
			fin_pos = '0;
		end else begin
			priority if (fault_state_q == FAULT_OVERLAP || fault_state_q == FAULT_STUCK) begin
				// sticky until the pedal is back under 5 %
				fin_pos = '0;
				if (recover_q) begin
					fin_state = FAULT_NONE;
					fin_ticks = '0;
				end
			end else if ((fault_state_q == FAULT_OPEN_SHORT
					|| fault_state_q == FAULT_DIFFER) && flag_q) begin
				fin_pos = '0;
			end else if (flag_q) begin
				fin_state = FAULT_NONE;
			end else begin
				fin_state = FAULT_NONE;
				fin_ticks = '0;
			end
		end
		// passive read leaves the counter as it was
		if (!loop_q) begin
			fin_ticks = saved_q;
		end
	end

	// sequencer, configuration, fault state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q          <= S_IDLE;
			cnt_q          <= '0;
			primary_fs_q   <= PRIMARY_FS_RESET;
			secondary_fs_q <= SECONDARY_FS_RESET;
			fault_limit_q  <= FAULT_TICK_LIMIT_RESET;
			stuck_limit_q  <= STUCK_TICK_LIMIT_RESET;
			fault_state_q  <= FAULT_NONE;
			fault_ticks_q  <= '0;
			flag_q         <= 1'b0;
			res_valid_q    <= 1'b0;
			res_pos_q      <= '0;
			res_code_q     <= FAULT_NONE;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_PRIMARY_FS:   primary_fs_q   <= cfg.data[FS_BITS-1:0];
					CFG_SECONDARY_FS: secondary_fs_q <= cfg.data[FS_BITS-1:0];
					CFG_FAULT_LIMIT:  fault_limit_q  <= cfg.data[TICK_BITS-1:0];
					CFG_STUCK_LIMIT:  stuck_limit_q  <= cfg.data[TICK_BITS-1:0];
				endcase
			end

			if (commit) begin
				res_valid_q <= 1'b1;
				res_pos_q   <= fin_pos;
				res_code_q  <= fin_state;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (fsm_q)
				S_IDLE: begin
					if (sample.valid) begin
						flag_q <= 1'b0;
						fsm_q  <= S_DZ_P;
					end
				end
				S_DZ_P: fsm_q <= S_DZ_S;
				S_DZ_S: fsm_q <= S_CMP_A;
				S_CMP_A: begin
					cnt_q <= CNT_BITS'(FS_BITS - 1);
					fsm_q <= S_CMP_B;
				end
				S_CMP_B: fsm_q <= S_CMP_C;
				S_CMP_C: fsm_q <= S_MUL;
				S_MUL: begin
					if (cnt_q == '0) begin
						fsm_q <= S_ABS;
					end else begin
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
				S_ABS: fsm_q <= S_DIFF;
				S_DIFF: begin
					cnt_q <= CNT_BITS'(POS_BITS - 1);
					fsm_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						fsm_q <= S_CHK_ALARM;
					end else begin
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
				S_CHK_ALARM, S_CHK_DIFF, S_CHK_BRAKE, S_CHK_STUCK: begin
					// each check tests the counter as the previous one left it
					if (chk_hit) begin
						if (chk_over) begin
							fault_state_q <= chk_state;
						end
						fault_ticks_q <= ticks_inc;
						flag_q        <= 1'b1;
					end
					fsm_q <= chk_next;
				end
				S_FINAL: begin
					if (res_free) begin
						fault_state_q <= fin_state;
						fault_ticks_q <= fin_ticks;
						fsm_q         <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	// bit-serial datapath
	always_ff @(posedge clk) begin
		unique case (fsm_q)
			S_IDLE: begin
				if (in_take) begin
					loop_q  <= sample.loop_mode;
					brake_q <= sample.brake_pressed;
					alarm_q <= sample.primary_alarm || sample.secondary_alarm;
					p_q     <= VAL_BITS'(sample.primary_count);
					s_q     <= VAL_BITS'(sec_inv);
					// a zero full scale counts as one
					fsp_q   <= (primary_fs_q == '0) ? FS_BITS'(1) : primary_fs_q;
					fss_q   <= (secondary_fs_q == '0) ? FS_BITS'(1) : secondary_fs_q;
					saved_q <= fault_ticks_q;
					skip_q  <= (fault_state_q == FAULT_DIFFER);
					gate_q  <= !(fault_state_q == FAULT_OVERLAP
						|| fault_state_q == FAULT_STUCK);
				end
			end
			S_DZ_P: begin
				if (in_deadzone(p_q[COUNT_BITS-1:0], fsp_q)) begin
					p_q <= '0;
				end
			end
			S_DZ_S: begin
				if (in_deadzone(s_q[COUNT_BITS-1:0], fss_q)) begin
					s_q <= '0;
				end
			end
			S_CMP_A: begin
				range_bad_q <= (p_q > VAL_BITS'(fsp_q)) || (s_q > VAL_BITS'(fss_q));
				rem_q       <= num_w[NUM_BITS-1:POS_BITS];
				qn_q        <= num_w[POS_BITS-1:0];
				acc_q       <= '0;
				prod_q      <= '0;
				mul_p_q     <= fss_q;
				mul_s_q     <= fsp_q;
			end
			S_CMP_B: begin
				sat_q <= CMP_BITS'(p_q) * CMP_BITS'(SAT_P)
					> CMP_BITS'(fsp_q) * CMP_BITS'(SAT_FS);
				low_q <= CMP_BITS'(p_q) * CMP_BITS'(RELEASE_P) < CMP_BITS'(fsp_q);
			end
			S_CMP_C: begin
				over_q    <= CMP_BITS'(p_q) * CMP_BITS'(OVERLAP_P) > CMP_BITS'(fsp_q);
				recover_q <= CMP_BITS'(p_q) * CMP_BITS'(RECOVER_P) < CMP_BITS'(fsp_q);
			end
			S_MUL: begin
				// p*fss - s*fsp and fsp*fss, one full-scale bit per cycle
				acc_q   <= acc_next;
				prod_q  <= prod_next;
				mul_p_q <= {mul_p_q[FS_BITS-2:0], 1'b0};
				mul_s_q <= {mul_s_q[FS_BITS-2:0], 1'b0};
			end
			S_ABS: begin
				mag_q <= acc_q[ACC_BITS-1] ? acc_neg[MAG_BITS-1:0] : acc_q[MAG_BITS-1:0];
			end
			S_DIFF: begin
				differ_q <= DIFF_CMP_BITS'(mag_q) * DIFF_CMP_BITS'(DIFFER_MAG)
					> DIFF_CMP_BITS'(prod_q);
			end
			S_DIV: begin
				rem_q <= div_ge ? div_sub[FS_BITS-1:0] : div_t[FS_BITS-1:0];
				qn_q  <= {qn_q[POS_BITS-2:0], div_ge};
			end
			S_CHK_ALARM: begin
				priority if (brake_q || range_bad_q) begin
					pos_q <= '0;
				end else if (sat_q) begin
					pos_q <= POS_FULL;
				end else if (low_q) begin
					pos_q <= '0;
				end else begin
					pos_q <= qn_q;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// open/short state is never entered
	a_no_open_short: assert property (@(posedge clk) disable iff (!arst_n)
		fault_state_q != FAULT_OPEN_SHORT)
		else $error("fault state 1 entered");

	// state 2 left at the end of a word latches until reset
	a_state2_latch: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == S_IDLE && fault_state_q == FAULT_DIFFER |=> fault_state_q == FAULT_DIFFER)
		else $error("latched fault state 2 left without reset");

	// a nonzero position is only reported with no fault
	a_pos_needs_normal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_pos_q != '0 |-> res_code_q == FAULT_NONE)
		else $error("pedal position reported while a fault is active");

	// passive read restores the counter
	a_passive_restore: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !loop_q |=> fault_ticks_q == $past(saved_q))
		else $error("passive read changed the fault counter");

endmodule

>>> bench/pedal_sensor_plausibility_check_tb.sv
// self-checking bench for the pedal sensor plausibility check against a local model of its fault logic
module pedal_sensor_plausibility_check_tb;
	import pspc_pkg::*;

	// generous ceiling: ~1250 words plus random gaps and stalls
	localparam int unsigned CYCLE_LIMIT = 600000;
	// quiet time after the last word, a bit more than one word's work in the datapath
	localparam int unsigned SETTLE = 60;
	localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;

	// idling profiles per phase
	localparam int unsigned IDLE_NONE = 0;
	localparam int unsigned IDLE_SEND = 1;
	localparam int unsigned IDLE_TAKE = 2;
	localparam int unsigned IDLE_BOTH = 3;

	typedef struct packed {
		logic                  loop_mode;
		logic [COUNT_BITS-1:0] primary_count;
		logic [COUNT_BITS-1:0] secondary_count;
		logic                  brake_pressed;
		logic                  primary_alarm;
		logic                  secondary_alarm;
	} reading_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   pedal_position;
		logic [FAULT_BITS-1:0] fault_code;
	} pedal_word_t;

	typedef struct packed {
		cfg_index_t               index;
		logic [CFG_DATA_BITS-1:0] data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	pspc_in_if  sample ();
	pspc_out_if result ();
	pspc_cfg_if cfg ();

	pedal_sensor_plausibility_check dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	reading_t    readings_to_send[$];
	reg_write_t  reg_writes_to_send[$];
	pedal_word_t pedal_words_due[$];

	int unsigned send_idle_pct = 0;
	int unsigned take_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// local copy of the block's registers and fault state
	logic [FS_BITS-1:0]   fs_primary;
	logic [FS_BITS-1:0]   fs_secondary;
	logic [TICK_BITS-1:0] limit_fault;
	logic [TICK_BITS-1:0] limit_stuck;
	fault_code_t          fault_now;
	logic [TICK_BITS-1:0] ticks_now;

	// ------------------------------------------------------------------
	// model of the plausibility check
	// ------------------------------------------------------------------

	// the tick counter saturates at all ones
	function automatic void bump_ticks();
		if (ticks_now != '1)
			ticks_now = ticks_now + 1'b1;
	endfunction

	// within 3 % of full scale from zero, or from the wrap point
	function automatic bit in_deadzone(logic [63:0] x, logic [63:0] fs);
		return (x * 64'd100 < fs * 64'd3) || ((COUNT_TOP - x) * 64'd100 < fs * 64'd3);
	endfunction

	// one reading in, one word out; updates the fault state and tick counter
	function automatic pedal_word_t pedal_check_step(reading_t r);
		logic [63:0]          p;
		logic [63:0]          s;
		logic [63:0]          fsp;
		logic [63:0]          fss;
		logic [63:0]          a;
		logic [63:0]          b;
		logic [63:0]          diff;
		logic [63:0]          pos;
		logic [TICK_BITS-1:0] saved;
		logic                 flag;
		pedal_word_t          w;

		p     = 64'(r.primary_count);
		// secondary encoder counts downward
		s     = COUNT_TOP - 64'(r.secondary_count);
		// a zero full scale acts as one
		fsp   = (fs_primary == '0) ? 64'd1 : 64'(fs_primary);
		fss   = (fs_secondary == '0) ? 64'd1 : 64'(fs_secondary);
		saved = ticks_now;
		pos   = '0;
		flag  = 1'b0;

		// the alarm escalation lands on code 2 and holds there until reset
		if (fault_now != FAULT_DIFFER) begin
			if (in_deadzone(p, fsp))
				p = '0;
			if (in_deadzone(s, fss))
				s = '0;

			if (r.brake_pressed)
				pos = '0;
			else if (p > fsp || s > fss)
				pos = '0;
			else if (p * 64'd5 > fsp * 64'd4)
				pos = 64'(POSITION_MAX);
			else if (p * 64'd25 < fsp)
				pos = '0;
			else
				pos = p * 64'(POSITION_MAX) / fsp;

			if (fault_now != FAULT_OVERLAP && fault_now != FAULT_STUCK) begin
				if (r.primary_alarm || r.secondary_alarm) begin
					if (ticks_now > limit_fault)
						fault_now = FAULT_DIFFER;
					bump_ticks();
					flag = 1'b1;
				end
				a    = p * fss;
				b    = s * fsp;
				diff = (a > b) ? a - b : b - a;
				// sensors more than 10 % apart, scaled to a common base
				if (diff * 64'd10 > fsp * fss) begin
					if (ticks_now > limit_fault)
						fault_now = FAULT_OVERLAP;
					bump_ticks();
					flag = 1'b1;
				end
			end

			// pedal past 25 % while braking
			if (p * 64'd4 > fsp && r.brake_pressed) begin
				if (ticks_now > limit_fault)
					fault_now = FAULT_OVERLAP;
				bump_ticks();
				flag = 1'b1;
			end

			if (pos == 64'(POSITION_MAX)) begin
				if (ticks_now > limit_stuck)
					fault_now = FAULT_STUCK;
				bump_ticks();
				flag = 1'b1;
			end

			if (fault_now == FAULT_OVERLAP || fault_now == FAULT_STUCK) begin
				pos = '0;
				// sticky until the pedal is back under 5 %
				if (p * 64'd20 < fsp) begin
					fault_now = FAULT_NONE;
					ticks_now = '0;
				end
			end else if ((fault_now == FAULT_OPEN_SHORT || fault_now == FAULT_DIFFER) && flag) begin
				pos = '0;
			end else if (flag) begin
				fault_now = FAULT_NONE;
			end else begin
				fault_now = FAULT_NONE;
				ticks_now = '0;
			end
		end

		// passive read leaves the counter as it was
		if (!r.loop_mode)
			ticks_now = saved;

		w.pedal_position = pos[POS_BITS-1:0];
		w.fault_code     = fault_now;
		return w;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// s is the secondary reading after inversion, which keeps the directed list readable
	function automatic reading_t reading(logic loop, logic [63:0] p, logic [63:0] s,
			logic brake, logic pa, logic sa);
		reading_t r;

		r.loop_mode       = loop;
		r.primary_count   = p[COUNT_BITS-1:0];
		r.secondary_count = COUNT_BITS'(COUNT_TOP - s);
		r.brake_pressed   = brake;
		r.primary_alarm   = pa;
		r.secondary_alarm = sa;
		return r;
	endfunction

	// pedal held around one spot for a run of words, sensors mostly in agreement
	task automatic queue_random_readings(int unsigned n, int unsigned alarm_pct);
		logic [63:0] fsp;
		logic [63:0] fss;
		logic [63:0] aim;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] spread;
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] s;
		int unsigned run_left;
		int unsigned pick;
		int unsigned i;
		logic        hold_brake;

		fsp        = (fs_primary == '0) ? 64'd1 : 64'(fs_primary);
		fss        = (fs_secondary == '0) ? 64'd1 : 64'(fs_secondary);
		spread     = fsp / 64;
		run_left   = 0;
		aim        = '0;
		hold_brake = 1'b0;
		for (i = 0; i < n; i++) begin
			if (run_left == 0) begin
				run_left   = $urandom_range(12, 1);
				hold_brake = ($urandom_range(99) < 15);
				pick       = $urandom_range(99);
				if (pick < 20) begin
					// released, around the recovery and release points
					lo = '0;
					hi = fsp / 20 + 1;
				end else if (pick < 40) begin
					// near full travel
					lo = fsp * 4 / 5;
					hi = fsp;
				end else if (pick < 70) begin
					lo = '0;
					hi = fsp;
				end else if (pick < 80) begin
					// beyond full scale
					lo = fsp;
					hi = fsp * 2;
				end else if (pick < 90) begin
					// just under the wrap point
					lo = COUNT_TOP - (fsp / 20 + 1);
					hi = COUNT_TOP;
				end else begin
					lo = '0;
					hi = COUNT_TOP;
				end
				if (hi > COUNT_TOP)
					hi = COUNT_TOP;
				aim = lo + 64'($urandom_range(32'(hi - lo)));
			end

			t = aim + 64'($urandom_range(32'(2 * spread)));
			p = (t < spread) ? 64'd0 : t - spread;
			if (p > COUNT_TOP)
				p = COUNT_TOP;

			if ($urandom_range(99) < 85)
				s = p * fss / fsp;
			else
				s = 64'($urandom_range(32'(COUNT_TOP)));
			if (s > COUNT_TOP)
				s = COUNT_TOP;

			readings_to_send.push_back(reading($urandom_range(99) < 85, p, s, hold_brake,
					$urandom_range(99) < alarm_pct, $urandom_range(99) < alarm_pct));
			run_left--;
		end
	endtask

	// nothing left to send and every word back
	task automatic wait_drained();
		while (readings_to_send.size() != 0 || sample.valid || pedal_words_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(logic [31:0] fsp, logic [31:0] fss, logic [31:0] flim,
			logic [31:0] slim, int unsigned idling, int unsigned alarm_pct, int unsigned n);
		wait_drained();
		// let the datapath go quiet before touching registers
		repeat (SETTLE) @(negedge clk);
		reg_writes_to_send.push_back('{index: CFG_PRIMARY_FS, data: fsp});
		reg_writes_to_send.push_back('{index: CFG_SECONDARY_FS, data: fss});
		reg_writes_to_send.push_back('{index: CFG_FAULT_LIMIT, data: flim});
		reg_writes_to_send.push_back('{index: CFG_STUCK_LIMIT, data: slim});
		while (reg_writes_to_send.size() != 0 || cfg.valid)
			@(negedge clk);

		case (idling)
			IDLE_SEND: begin
				send_idle_pct  = 72;
				take_stall_pct = 0;
			end
			IDLE_TAKE: begin
				send_idle_pct  = 0;
				take_stall_pct = 72;
			end
			IDLE_BOTH: begin
				send_idle_pct  = 34;
				take_stall_pct = 34;
			end
			default: begin
				send_idle_pct  = 0;
				take_stall_pct = 0;
			end
		endcase
		queue_random_readings(n, alarm_pct);
	endtask

	// ------------------------------------------------------------------
	// clock, known inputs from time zero
	// ------------------------------------------------------------------
	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		sample.valid           = 1'b0;
		sample.loop_mode       = 1'b0;
		sample.primary_count   = '0;
		sample.secondary_count = '0;
		sample.brake_pressed   = 1'b0;
		sample.primary_alarm   = 1'b0;
		sample.secondary_alarm = 1'b0;
		result.ready           = 1'b0;
		cfg.valid              = 1'b0;
		cfg.index              = CFG_PRIMARY_FS;
		cfg.data               = '0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// ------------------------------------------------------------------
	// sample driver: a word stays up until taken, gaps only between words
	// ------------------------------------------------------------------
	always @(posedge clk) begin : send_readings
		reading_t r;

		if (!arst_n) begin
			sample.valid <= 1'b0;
		end else if (!sample.valid || sample.ready) begin
			if (readings_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				r = readings_to_send.pop_front();
				sample.valid           <= 1'b1;
				sample.loop_mode       <= r.loop_mode;
				sample.primary_count   <= r.primary_count;
				sample.secondary_count <= r.secondary_count;
				sample.brake_pressed   <= r.brake_pressed;
				sample.primary_alarm   <= r.primary_alarm;
				sample.secondary_alarm <= r.secondary_alarm;
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk)
		result.ready <= arst_n && ($urandom_range(99) >= take_stall_pct);

	// register writes, only queued while the block is idle
	always @(posedge clk) begin : send_reg_writes
		reg_write_t w;

		if (!arst_n) begin
			cfg.valid <= 1'b0;
		end else if (!cfg.valid || cfg.ready) begin
			if (reg_writes_to_send.size() != 0) begin
				w = reg_writes_to_send.pop_front();
				cfg.valid <= 1'b1;
				cfg.index <= w.index;
				cfg.data  <= w.data;
			end else begin
				cfg.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: follow register writes and samples, check every result word
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		pedal_word_t due;
		reading_t    taken;

		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (pedal_words_due.size() == 0) begin
					$display("%0t: result word with none due: position %0d fault %0d",
							$time, result.pedal_position, result.fault_code);
					mismatches++;
				end else begin
					due = pedal_words_due.pop_front();
					if (result.pedal_position !== due.pedal_position) begin
						$display("%0t: pedal_position expected %0d actual %0d",
								$time, due.pedal_position, result.pedal_position);
						mismatches++;
					end
					if (result.fault_code !== due.fault_code) begin
						$display("%0t: fault_code expected %0d actual %0d",
								$time, due.fault_code, result.fault_code);
						mismatches++;
					end
				end
			end

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_PRIMARY_FS:   fs_primary   = cfg.data[FS_BITS-1:0];
					CFG_SECONDARY_FS: fs_secondary = cfg.data[FS_BITS-1:0];
					CFG_FAULT_LIMIT:  limit_fault  = cfg.data[TICK_BITS-1:0];
					CFG_STUCK_LIMIT:  limit_stuck  = cfg.data[TICK_BITS-1:0];
					default: ;
				endcase
			end

			if (sample.valid && sample.ready) begin
				taken.loop_mode       = sample.loop_mode;
				taken.primary_count   = sample.primary_count;
				taken.secondary_count = sample.secondary_count;
				taken.brake_pressed   = sample.brake_pressed;
				taken.primary_alarm   = sample.primary_alarm;
				taken.secondary_alarm = sample.secondary_alarm;
				pedal_words_due.push_back(pedal_check_step(taken));
			end
		end
	end

	// ------------------------------------------------------------------
	// run sequence
	// ------------------------------------------------------------------
	initial begin
		// register defaults and a clean fault state, as after reset
		fs_primary   = 16'd1400;
		fs_secondary = 16'd1950;
		limit_fault  = 32'd1000;
		limit_stuck  = 32'd10000;
		fault_now    = FAULT_NONE;
		ticks_now    = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the reset settings (full scales 1400 / 1950)
		readings_to_send.push_back(reading(1, 0, 0, 0, 0, 0));          // pedal at rest
		readings_to_send.push_back(reading(1, 65535, 65535, 0, 0, 0));  // both at the wrap point
		readings_to_send.push_back(reading(1, 41, 61, 0, 0, 0));        // deadzone edge
		readings_to_send.push_back(reading(1, 42, 58, 0, 0, 0));
		readings_to_send.push_back(reading(1, 55, 77, 0, 0, 0));        // release band
		readings_to_send.push_back(reading(1, 700, 975, 0, 0, 0));      // mid travel
		readings_to_send.push_back(reading(1, 1120, 1560, 0, 0, 0));    // right at 80 %
		readings_to_send.push_back(reading(1, 1121, 1561, 0, 0, 0));    // saturated
		readings_to_send.push_back(reading(1, 1400, 1950, 0, 0, 0));    // full travel
		readings_to_send.push_back(reading(1, 1401, 1951, 0, 0, 0));    // over range
		readings_to_send.push_back(reading(1, 700, 975, 1, 0, 0));      // brake overlap
		readings_to_send.push_back(reading(1, 350, 487, 1, 0, 0));      // brake at exactly 25 %
		readings_to_send.push_back(reading(1, 700, 0, 0, 0, 0));        // sensors disagree
		readings_to_send.push_back(reading(0, 700, 0, 0, 0, 0));        // passive read
		readings_to_send.push_back(reading(1, 700, 975, 0, 1, 0));      // primary alarm
		readings_to_send.push_back(reading(1, 700, 975, 0, 0, 1));      // secondary alarm
		readings_to_send.push_back(reading(1, 0, 0, 0, 0, 0));
		readings_to_send.push_back(reading(1, 69, 97, 0, 0, 0));        // just under recovery
		readings_to_send.push_back(reading(1, 70, 97, 0, 0, 0));
		readings_to_send.push_back(reading(0, 1400, 1950, 0, 0, 0));
		readings_to_send.push_back(reading(1, 30000, 35535, 0, 0, 0));
		readings_to_send.push_back(reading(0, 32768, 32768, 1, 1, 1));

		// random phases; alarms only where they cannot latch the block early
		run_phase(32'd1400, 32'd1950, 32'd1000, 32'd10000, IDLE_NONE, 0, 155);
		run_phase(32'd1, 32'd65535, '1, '1, IDLE_SEND, 30, 155);
		// zero full scales act as one
		run_phase(32'd0, 32'd0, 32'd3, 32'd5, IDLE_TAKE, 0, 155);
		run_phase(32'd65535, 32'd1, 32'd0, 32'd0, IDLE_BOTH, 0, 155);
		run_phase($urandom_range(5000, 100), $urandom_range(5000, 100), 32'd2, 32'd4,
				IDLE_NONE, 0, 155);
		run_phase(32'd65535, 32'd65535, '1, 32'd7, IDLE_SEND, 20, 155);
		run_phase($urandom_range(65535, 1), $urandom_range(65535, 1), $urandom_range(10, 1),
				$urandom_range(10, 1), IDLE_TAKE, 0, 155);
		// last phase: alarms with a tiny limit, so the latched state is reached and held
		run_phase(32'd1400, 32'd1950, 32'd1, 32'd3, IDLE_BOTH, 10, 155);

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("pedal_sensor_plausibility_check_tb: PASS");
		else
			$display("pedal_sensor_plausibility_check_tb: FAIL");
		$finish;
	end

	// hung handshake guard
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("pedal_sensor_plausibility_check_tb: FAIL");
		$finish;
	end

endmodule
